// ===== hdl/rlt_pkg.sv =====
// Shared types, sizes and codes for the record lock table.
package rlt_pkg;

   // Table geometry and tag widths
   localparam int TABLE_ENTRIES = 64;
   localparam int KEY_BITS      = 32;
   localparam int TXN_BITS      = 32;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int FREED_BITS    = 7;

   // Request action codes
   localparam logic [1:0] ACT_ACQUIRE     = 2'd0;
   localparam logic [1:0] ACT_RELEASE_KEY = 2'd1;
   localparam logic [1:0] ACT_RELEASE_ALL = 2'd2;

   // Response status codes
   localparam logic [2:0] STS_GRANT_NEW   = 3'd0;
   localparam logic [2:0] STS_GRANT_OWN   = 3'd1;
   localparam logic [2:0] STS_CONFLICT    = 3'd2;
   localparam logic [2:0] STS_TABLE_FULL  = 3'd3;
   localparam logic [2:0] STS_RELEASED    = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic        lock_mode;
      logic [31:0] key_tag;
      logic [31:0] txn_id;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic                  key_still_locked;
      logic [FREED_BITS-1:0] entries_freed;
   } rsp_type;

   // One stored lock entry; its valid bit lives in flip-flops
   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TXN_BITS-1:0] owner;
      logic                exclusive;
   } ent_type;

   localparam int ENT_BITS = $bits(ent_type);

endpackage

// ===== hdl/rlt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, and read one word into a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/record_lock_table_core.sv =====
// Record lock table: shared/exclusive locks on key tags, one request at a time.
//
// Requests arrive on the req_ channel (valid/ready) and carry an action, a
// lock mode, a key tag and a transaction id. Each request yields exactly one
// response on the rsp_ channel: a status, whether the key is still locked and
// how many entries a release freed.
// Each request walks the whole table through the entry RAM, one entry a
// cycle. The response is registered after the scan, and the next request is
// taken in the cycle after the response is loaded, so a new request is not
// taken before the block is through with the last one.
// The single read port of the entry RAM sets this pace.
// Reset clears all entry valid bits at once; the RAM contents are only
// read behind a set valid bit. A stalled response sits in the output register
// while the next request is already taken and scanned; the scan then holds in
// its final cycle until the output register is free.
module record_lock_table_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rlt_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rlt_pkg::rsp_type rsp_data
);
   import rlt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_BITS-1:0]     cnt_ff, cnt_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [IDX_BITS-1:0]     chk_idx_ff, chk_idx_in;
   req_type                 req_ff, req_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                    conflict_ff, conflict_in;
   logic                    have_own_ff, have_own_in;
   logic [IDX_BITS-1:0]     own_slot_ff, own_slot_in;
   logic                    have_free_ff, have_free_in;
   logic [IDX_BITS-1:0]     free_slot_ff, free_slot_in;
   logic                    key_left_ff, key_left_in;
   logic [FREED_BITS-1:0]   freed_ff, freed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    rd_en;
   logic [ENT_BITS-1:0]     rd_word;
   ent_type                 ent;
   logic                    wr_en;
   logic [IDX_BITS-1:0]     wr_addr;
   ent_type                 wr_ent;

   logic [KEY_BITS-1:0]     req_key;
   logic [TXN_BITS-1:0]     req_txn;
   logic                    is_acquire;
   logic                    ent_live;
   logic                    key_hit;
   logic                    own_hit;
   logic                    rel_hit;
   logic                    out_free;
   logic [2:0]              fin_status;
   logic                    fin_locked;

   // Entry store: key, owner and mode of every slot
   rlt_ram #(
      .WIDTH (ENT_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_word)
   );

   assign ent     = ent_type'(rd_word);
   assign req_key = req_ff.key_tag[KEY_BITS-1:0];
   assign req_txn = req_ff.txn_id[TXN_BITS-1:0];
   assign is_acquire = (req_ff.action == ACT_ACQUIRE);

   // Classify the entry returned by the RAM
   assign ent_live = valid_ff[chk_idx_ff];
   assign key_hit  = ent_live && (ent.key == req_key);
   assign own_hit  = key_hit && (ent.owner == req_txn);
   assign rel_hit  = ent_live && (ent.owner == req_txn) &&
                     ((req_ff.action == ACT_RELEASE_ALL) ||
                      ((req_ff.action == ACT_RELEASE_KEY) && (ent.key == req_key)));

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Settle the outcome of a request once the scan is complete
   always_comb begin
      if (!is_acquire) begin
         fin_status = STS_RELEASED;
      end else if (conflict_ff) begin
         fin_status = STS_CONFLICT;
      end else if (have_own_ff) begin
         fin_status = STS_GRANT_OWN;
      end else if (!have_free_ff) begin
         fin_status = STS_TABLE_FULL;
      end else begin
         fin_status = STS_GRANT_NEW;
      end
      fin_locked = key_left_ff || (fin_status == STS_GRANT_NEW);
   end

   // Write back a retyped or new entry when the acquire is granted
   always_comb begin
      wr_en            = (state_ff == ST_FINISH) && out_free && is_acquire &&
                         !conflict_ff && (have_own_ff || have_free_ff);
      wr_addr          = have_own_ff ? own_slot_ff : free_slot_ff;
      wr_ent.key       = req_key;
      wr_ent.owner     = req_txn;
      wr_ent.exclusive = req_ff.lock_mode;
   end

   assign rd_en = (state_ff == ST_SCAN);

   // Sequencer and scan accumulators
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = cnt_ff;
      req_in       = req_ff;
      valid_in     = valid_ff;
      conflict_in  = conflict_ff;
      have_own_in  = have_own_ff;
      own_slot_in  = own_slot_ff;
      have_free_in = have_free_ff;
      free_slot_in = free_slot_ff;
      key_left_in  = key_left_ff;
      freed_in     = freed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = (state_ff == ST_IDLE);

      // Fold in one entry from the RAM
      if (chk_vld_ff) begin
         if (!ent_live && !have_free_ff) begin
            have_free_in = 1'b1;
            free_slot_in = chk_idx_ff;
         end
         if (is_acquire && own_hit && !have_own_ff) begin
            have_own_in = 1'b1;
            own_slot_in = chk_idx_ff;
         end
         if (is_acquire && key_hit && !own_hit &&
             (req_ff.lock_mode || ent.exclusive)) begin
            conflict_in = 1'b1;
         end
         if (key_hit && !rel_hit) begin
            key_left_in = 1'b1;
         end
         if (rel_hit) begin
            valid_in[chk_idx_ff] = 1'b0;
            if (freed_ff != {FREED_BITS{1'b1}}) begin
               freed_in = freed_ff + FREED_BITS'(1);
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               cnt_in       = '0;
               conflict_in  = 1'b0;
               have_own_in  = 1'b0;
               have_free_in = 1'b0;
               key_left_in  = 1'b0;
               freed_in     = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            chk_vld_in = 1'b1;
            if (cnt_ff == IDX_BITS'(TABLE_ENTRIES - 1)) begin
               state_in = ST_LAST;
            end else begin
               cnt_in = cnt_ff + IDX_BITS'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               if (wr_en && !have_own_ff) begin
                  valid_in[free_slot_ff] = 1'b1;
               end
               rsp_valid_in            = 1'b1;
               rsp_in.status           = fin_status;
               rsp_in.key_still_locked = fin_locked;
               rsp_in.entries_freed    = is_acquire ? '0 : freed_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      chk_idx_ff   <= chk_idx_in;
      req_ff       <= req_in;
      conflict_ff  <= conflict_in;
      have_own_ff  <= have_own_in;
      own_slot_ff  <= own_slot_in;
      have_free_ff <= have_free_in;
      free_slot_ff <= free_slot_in;
      key_left_ff  <= key_left_in;
      freed_ff     <= freed_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // No entry is still being folded in while a new request can be taken
   a_idle_no_check: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !chk_vld_ff)
      else $error("entry check pending while idle");

   // A response only appears out of the final step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   // A new grant leaves its slot marked valid
   a_new_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !have_own_ff) |=> valid_ff[$past(free_slot_ff)])
      else $error("new entry not marked valid");

   // The freed count never exceeds the table size
   a_freed_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> freed_ff <= FREED_BITS'(TABLE_ENTRIES))
      else $error("freed count beyond table size");

   // Reads only happen while scanning, writes only when finishing
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en && !chk_vld_ff)
      else $error("entry write overlaps scan");

endmodule
